### src/i2cm_pkg.sv
// Shared types, codes and constants of the I2C master transaction engine.
package i2cm_pkg;

  localparam int unsigned ReadSlotsDef    = 4;
  localparam int unsigned WriteSlotsDef   = 4;
  localparam int unsigned MaxReadLenDef   = 8;

  localparam logic [1:0] CMD_RD_ENQ = 2'd0;
  localparam logic [1:0] CMD_WR_ENQ = 2'd1;
  localparam logic [1:0] CMD_BUS    = 2'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_RX_ACK  = 3'd4;
  localparam logic [2:0] ACT_RX_NACK = 3'd5;
  localparam logic [2:0] ACT_RELEASE = 3'd6;

  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_BUSY    = 2'd1;
  localparam logic [1:0] RC_INVALID = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_ADDR     = 3'd1;
  localparam logic [2:0] ERR_DATA     = 3'd2;
  localparam logic [2:0] ERR_ARB      = 3'd3;
  localparam logic [2:0] ERR_BUS      = 3'd4;

  localparam logic [1:0] MODE_READY     = 2'd0;
  localparam logic [1:0] MODE_REG_READ  = 2'd1;
  localparam logic [1:0] MODE_RMW_READ  = 2'd2;
  localparam logic [1:0] MODE_RMW_WRITE = 2'd3;

  localparam logic [4:0] ST_START    = 5'h01;
  localparam logic [4:0] ST_RSTART   = 5'h02;
  localparam logic [4:0] ST_SLAW_ACK = 5'h03;
  localparam logic [4:0] ST_SLAW_NAK = 5'h04;
  localparam logic [4:0] ST_DATW_ACK = 5'h05;
  localparam logic [4:0] ST_DATW_NAK = 5'h06;
  localparam logic [4:0] ST_ARB      = 5'h07;
  localparam logic [4:0] ST_SLAR_ACK = 5'h08;
  localparam logic [4:0] ST_SLAR_NAK = 5'h09;
  localparam logic [4:0] ST_DATR_ACK = 5'h0A;
  localparam logic [4:0] ST_DATR_NAK = 5'h0B;
  localparam logic [4:0] ST_BUS_ERR  = 5'h00;

  // Slot word: valid, device, register, value, mask, length.
  typedef struct packed {
    logic       valid;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] value;
    logic [7:0] mask;
    logic [3:0] len;
  } slot_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [2:0] read_index;
    logic [1:0] reply_code;
    logic [2:0] error_kind;
    logic       last;
  } result_t;

endpackage

### src/i2c_master_transaction_engine_core.sv
// Top level of the I2C master transaction engine.
// The first result is offered once its request is registered and executed (EXEC); a stop,
// or an enqueue while ready, passes through dispatch (DISP) first, and a starting slot adds
// its registered slot read (LOAD) after the pick. Input is held off until all results are
// taken. A second result, when there is one, follows the first.
// Reset clears all slot valid bits, mode and recorded error at once.
module i2c_master_transaction_engine_core
  import i2cm_pkg::*;
#(
  parameter int unsigned READ_SLOTS      = ReadSlotsDef,
  parameter int unsigned WRITE_SLOTS     = WriteSlotsDef,
  parameter int unsigned MAX_READ_LENGTH = MaxReadLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  // priority_req[2:0] device_address[9:3] register_address[17:10] read_length[21:18]
  // write_value[29:22] write_mask[37:30] bus_status[45:38] bus_data[53:46] zero[55:54]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_valid[0]
  output logic        m_axis_tuser,
  // bus_action[2:0] send_byte[10:3] read_byte[18:11] read_index[21:19]
  // reply_code[23:22] error_kind[26:24] zero[31:27]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned RIdxW = (READ_SLOTS > 1) ? $clog2(READ_SLOTS) : 1;
  localparam int unsigned WIdxW = (WRITE_SLOTS > 1) ? $clog2(WRITE_SLOTS) : 1;
  localparam int unsigned MaxP  = (READ_SLOTS > WRITE_SLOTS) ? READ_SLOTS : WRITE_SLOTS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_OUT1  = 3'd4;
  localparam logic [2:0] S_OUT2  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [55:0] in_q;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  addr_q, addr_d, areg_q, areg_d, mval_q, mval_d, mmsk_q, mmsk_d;
  logic [3:0]  bidx_q, bidx_d, blim_q, blim_d;
  logic [2:0]  err_q, err_d;
  logic [7:0]  wbuf0_q, wbuf0_d, wbuf1_q, wbuf1_d;
  result_t     r0_q, r0_d, r1_q, r1_d;
  logic        two_q, two_d;
  logic        disp_rd_q, disp_rd_d;

  logic [1:0] cmd;
  logic [2:0] prio;
  logic [6:0] dev;
  logic [7:0] regb, wval, wmsk, data;
  logic [3:0] len, len_c;
  logic [4:0] st;

  assign cmd  = in_q[1:0];
  assign prio = in_q[4:2];
  assign dev  = in_q[11:5];
  assign regb = in_q[19:12];
  assign len  = in_q[23:20];
  assign wval = in_q[31:24];
  assign wmsk = in_q[39:32];
  assign data = in_q[55:48];
  assign st   = in_q[47:43];

  // memories
  logic rd_wr_en, wr_wr_en, rd_clr, wr_clr, rd_rd_en, wr_rd_en;
  logic [RIdxW-1:0] rd_ridx, rd_clr_idx;
  logic [WIdxW-1:0] wr_ridx, wr_clr_idx;
  slot_t rd_wdata, wr_wdata, rd_rdata, wr_rdata;
  logic [READ_SLOTS-1:0]  rd_valid;
  logic [WRITE_SLOTS-1:0] wr_valid;

  i2cm_slot_mem #(.Slots(READ_SLOTS)) u_rd_mem (
    .clk_i, .rst_ni,
    .rd_en_i(rd_rd_en), .rd_idx_i(rd_ridx), .rd_data_o(rd_rdata),
    .wr_en_i(rd_wr_en), .wr_idx_i(prio[RIdxW-1:0]), .wr_data_i(rd_wdata),
    .clr_en_i(rd_clr), .clr_idx_i(rd_clr_idx), .valid_o(rd_valid)
  );

  i2cm_slot_mem #(.Slots(WRITE_SLOTS)) u_wr_mem (
    .clk_i, .rst_ni,
    .rd_en_i(wr_rd_en), .rd_idx_i(wr_ridx), .rd_data_o(wr_rdata),
    .wr_en_i(wr_wr_en), .wr_idx_i(prio[WIdxW-1:0]), .wr_data_i(wr_wdata),
    .clr_en_i(wr_clr), .clr_idx_i(wr_clr_idx), .valid_o(wr_valid)
  );

  // priority pick over valid bits
  logic             pick_any, pick_rd;
  logic [RIdxW-1:0] pick_ridx;
  logic [WIdxW-1:0] pick_widx;
  always_comb begin
    pick_any  = 1'b0;
    pick_rd   = 1'b0;
    pick_ridx = '0;
    pick_widx = '0;
    for (int p = MaxP - 1; p >= 0; p--) begin
      if (p < WRITE_SLOTS && wr_valid[p]) begin
        pick_any = 1'b1; pick_rd = 1'b0; pick_widx = WIdxW'(p);
      end
      if (p < READ_SLOTS && rd_valid[p]) begin
        pick_any = 1'b1; pick_rd = 1'b1; pick_ridx = RIdxW'(p);
      end
    end
  end

  // enqueue decode
  logic [1:0] enq_rc;
  logic       rd_busy, wr_busy;
  always_comb begin
    rd_busy = 1'b0;
    wr_busy = 1'b0;
    for (int p = 0; p < READ_SLOTS; p++) begin
      if (prio == 3'(p)) rd_busy = rd_valid[p];
    end
    for (int p = 0; p < WRITE_SLOTS; p++) begin
      if (prio == 3'(p)) wr_busy = wr_valid[p];
    end
    if (cmd == CMD_RD_ENQ) begin
      enq_rc = ({1'b0, prio} >= 4'(READ_SLOTS)) ? RC_INVALID :
               (rd_busy ? RC_BUSY : RC_OK);
    end else begin
      enq_rc = ({1'b0, prio} >= 4'(WRITE_SLOTS)) ? RC_INVALID :
               (wr_busy ? RC_BUSY : RC_OK);
    end
    len_c = (len == 4'd0) ? 4'd1 :
            ((len > 4'(MAX_READ_LENGTH)) ? 4'(MAX_READ_LENGTH) : len);
  end

  always_comb begin
    rd_wdata          = '0;
    rd_wdata.valid    = 1'b1;
    rd_wdata.dev      = dev;
    rd_wdata.reg_addr = regb;
    rd_wdata.len      = len_c;
    wr_wdata          = '0;
    wr_wdata.valid    = 1'b1;
    wr_wdata.dev      = dev;
    wr_wdata.reg_addr = regb;
    wr_wdata.value    = wval;
    wr_wdata.mask     = wmsk;
  end

  function automatic result_t mk(input logic [2:0] act, input logic [7:0] sb,
                                 input logic rv, input logic [7:0] rb,
                                 input logic [2:0] ri, input logic [1:0] rc,
                                 input logic [2:0] ek);
    result_t r;
    r.action     = act;
    r.send_byte  = sb;
    r.read_valid = rv;
    r.read_byte  = rv ? rb : 8'd0;
    r.read_index = rv ? ri : 3'd0;
    r.reply_code = rc;
    r.error_kind = ek;
    r.last       = 1'b0;
    return r;
  endfunction

  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  logic       addr_phase;
  logic [3:0] bidx_inc;
  logic       more;
  assign addr_phase = (mode_q == MODE_REG_READ) || (mode_q == MODE_RMW_READ);
  assign bidx_inc   = bidx_q + 4'd1;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    addr_d    = addr_q;
    areg_d    = areg_q;
    mval_d    = mval_q;
    mmsk_d    = mmsk_q;
    bidx_d    = bidx_q;
    blim_d    = blim_q;
    err_d     = err_q;
    wbuf0_d   = wbuf0_q;
    wbuf1_d   = wbuf1_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    two_d     = two_q;
    disp_rd_d = disp_rd_q;
    rd_wr_en  = 1'b0;
    wr_wr_en  = 1'b0;
    rd_clr    = 1'b0;
    wr_clr    = 1'b0;
    rd_rd_en  = 1'b0;
    wr_rd_en  = 1'b0;
    rd_ridx   = pick_ridx;
    wr_ridx   = pick_widx;
    rd_clr_idx = pick_ridx;
    wr_clr_idx = pick_widx;
    more      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        two_d   = 1'b0;
        state_d = S_OUT1;
        if (cmd == CMD_RD_ENQ || cmd == CMD_WR_ENQ) begin
          r0_d = mk(ACT_NONE, 8'd0, 1'b0, 8'd0, 3'd0, enq_rc, err_q);
          if (enq_rc == RC_OK) begin
            if (cmd == CMD_RD_ENQ) rd_wr_en = 1'b1;
            else wr_wr_en = 1'b1;
            if (mode_q == MODE_READY) begin
              two_d   = 1'b0;
              state_d = S_DISP;
            end
          end
        end else if (cmd != CMD_BUS) begin
          r0_d = mk(ACT_NONE, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
        end else begin
          r0_d = mk(ACT_NONE, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
          case (st)
            ST_START, ST_RSTART: begin
              r0_d = mk(ACT_SEND, addr_q, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
            end
            ST_SLAW_ACK, ST_DATW_ACK: begin
              if (addr_phase && st == ST_SLAW_ACK) begin
                r0_d = mk(ACT_SEND, areg_q, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
              end else if (addr_phase) begin
                r0_d   = mk(ACT_STOP, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
                r1_d   = mk(ACT_START, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
                two_d  = 1'b1;
                addr_d = addr_q | 8'd1;
              end else if (mode_q == MODE_RMW_WRITE && bidx_q < blim_q) begin
                r0_d = mk(ACT_SEND, bidx_q[0] ? wbuf1_q : wbuf0_q, 1'b0, 8'd0,
                          3'd0, RC_OK, err_q);
                bidx_d = bidx_inc;
              end else begin
                more = 1'b1;
              end
            end
            ST_SLAW_NAK: begin
              err_d = ERR_ADDR; more = 1'b1;
            end
            ST_DATW_NAK: begin
              err_d = ERR_DATA; more = 1'b1;
            end
            ST_ARB: begin
              err_d  = ERR_ARB;
              mode_d = MODE_READY;
              r0_d   = mk(ACT_RELEASE, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, ERR_ARB);
            end
            ST_SLAR_ACK: begin
              r0_d = mk((bidx_q < blim_q) ? ACT_RX_ACK : ACT_RX_NACK, 8'd0,
                        1'b0, 8'd0, 3'd0, RC_OK, err_q);
            end
            ST_DATR_ACK: begin
              if (mode_q == MODE_RMW_READ && bidx_q == 4'd0) wbuf0_d = data;
              bidx_d = bidx_inc;
              r0_d = mk((bidx_inc < blim_q) ? ACT_RX_ACK : ACT_RX_NACK, 8'd0,
                        mode_q == MODE_REG_READ, data, bidx_q[2:0], RC_OK, err_q);
            end
            ST_DATR_NAK: begin
              if (mode_q == MODE_RMW_READ) begin
                wbuf1_d = ((bidx_q == 4'd0 ? data : wbuf0_q) & ~mmsk_q) |
                          (mval_q & mmsk_q);
                wbuf0_d = areg_q;
                bidx_d  = 4'd0;
                blim_d  = 4'd2;
                mode_d  = MODE_RMW_WRITE;
                addr_d  = addr_q & 8'hFE;
                r0_d = mk(ACT_START, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, err_q);
              end else begin
                bidx_d = bidx_inc;
                more   = 1'b1;
              end
            end
            ST_SLAR_NAK: more = 1'b1;
            ST_BUS_ERR: begin
              err_d = ERR_BUS; more = 1'b1;
            end
            default: ;
          endcase
          if (more) begin
            mode_d = MODE_READY;
            r0_d = mk(ACT_STOP, 8'd0,
                      st == ST_DATR_NAK && mode_q == MODE_REG_READ, data,
                      bidx_q[2:0], RC_OK, err_d);
            state_d = S_DISP;
          end
        end
      end
      S_DISP: begin
        if (pick_any) begin
          disp_rd_d = pick_rd;
          rd_rd_en  = pick_rd;
          wr_rd_en  = !pick_rd;
          rd_clr    = pick_rd;
          wr_clr    = !pick_rd;
          state_d   = S_LOAD;
        end else begin
          state_d = S_OUT1;
        end
      end
      S_LOAD: begin
        err_d  = ERR_NONE;
        bidx_d = 4'd0;
        if (disp_rd_q) begin
          mode_d = MODE_REG_READ;
          addr_d = {rd_rdata.dev, 1'b0};
          areg_d = rd_rdata.reg_addr;
          blim_d = rd_rdata.len - 4'd1;
        end else begin
          mode_d = MODE_RMW_READ;
          addr_d = {wr_rdata.dev, 1'b0};
          areg_d = wr_rdata.reg_addr;
          mval_d = wr_rdata.value;
          mmsk_d = wr_rdata.mask;
          blim_d = 4'd0;
        end
        if (cmd == CMD_BUS) begin
          two_d = 1'b1;
          r1_d  = mk(ACT_START, 8'd0, 1'b0, 8'd0, 3'd0, RC_OK, ERR_NONE);
        end else begin
          r0_d.action     = ACT_START;
          r0_d.error_kind = ERR_NONE;
        end
        state_d = S_OUT1;
      end
      S_OUT1: begin
        if (out_fire) state_d = two_q ? S_OUT2 : S_IDLE;
      end
      S_OUT2: begin
        if (out_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= {s_axis_tdata[53:0], s_axis_tuser};
    r0_q      <= r0_d;
    r1_q      <= r1_d;
    two_q     <= two_d;
    disp_rd_q <= disp_rd_d;
    wbuf0_q   <= wbuf0_d;
    wbuf1_q   <= wbuf1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_READY;
      addr_q  <= '0;
      areg_q  <= '0;
      mval_q  <= '0;
      mmsk_q  <= '0;
      bidx_q  <= '0;
      blim_q  <= '0;
      err_q   <= ERR_NONE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      addr_q  <= addr_d;
      areg_q  <= areg_d;
      mval_q  <= mval_d;
      mmsk_q  <= mmsk_d;
      bidx_q  <= bidx_d;
      blim_q  <= blim_d;
      err_q   <= err_d;
    end
  end

  result_t r_out;
  always_comb begin
    r_out      = (state_q == S_OUT2) ? r1_q : r0_q;
    r_out.last = (state_q == S_OUT2) || !two_q;
  end

  assign m_axis_tvalid = (state_q == S_OUT1) || (state_q == S_OUT2);
  assign m_axis_tlast  = r_out.last;
  assign m_axis_tuser  = r_out.read_valid;
  assign m_axis_tdata  = {5'd0, r_out.error_kind, r_out.reply_code, r_out.read_index,
                          r_out.read_byte, r_out.send_byte, r_out.action};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("request accepted while busy");
  a_load_after_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> ($past(state_q) == S_DISP))
    else $error("slot load without dispatch");
  a_start_clears_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> (err_q == ERR_NONE))
    else $error("error not cleared on start");
  a_clear_picked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_clr || wr_clr) |-> pick_any)
    else $error("slot cleared with nothing pending");

endmodule

### src/i2cm_slot_mem.sv
// Slot memory: one synchronous RAM per queue with a valid bit per slot.
module i2cm_slot_mem
  import i2cm_pkg::*;
#(
  parameter int unsigned Slots = ReadSlotsDef,
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output slot_t           rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  slot_t           wr_data_i,
  input  logic            clr_en_i,
  input  logic [IdxW-1:0] clr_idx_i,
  output logic [Slots-1:0] valid_o
);

  slot_t            mem_q [Slots];
  slot_t            rd_q;
  logic [Slots-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_q;
  assign valid_o   = valid_q;

endmodule
